>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; modules take this file by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, switched off while reset is high
`define BPTC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked in reset as well
`define BPTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPTC_ASSERT(lbl, clk, rst, prop, msg)
`define BPTC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/bptc_pkg.sv
// Widths, register codes and pipeline stage types for the barometer compensation.
// No dependencies.
package bptc_pkg;

   // port widths
   localparam int RAW_W = 24;
   localparam int CAL_W = 16;
   localparam int OUT_W = 32;
   localparam int IDX_W = 3;

   // internal widths
   localparam int DT_W    = 25;   // D2 - C5*256
   localparam int PROD_W  = 42;   // dT times a calibration word
   localparam int DTSQ_W  = 48;   // dT squared, always below 2^48
   localparam int TEMP_W  = 19;   // temperature in 0.01 C
   localparam int ACC_W   = 40;   // OFF and SENS
   localparam int T2_W    = 17;   // dT^2 / 2^31
   localparam int SQ_W    = 35;   // (TEMP - 2000)^2 and (TEMP + 1500)^2
   localparam int CORR_W  = 38;   // OFF2 and SENS2
   localparam int SPLIT   = 20;   // low part of SENS for the split multiply
   localparam int PLO_W   = RAW_W + SPLIT;
   localparam int PHI_W   = RAW_W + 1 + ACC_W - SPLIT;
   localparam int PSH_W   = 45;   // D1*SENS / 2^21

   // shift amounts
   localparam int TEMP_SHIFT = 23;
   localparam int OFF_SHIFT  = 7;
   localparam int SENS_SHIFT = 8;
   localparam int T2_SHIFT   = 31;
   localparam int PROD_SHIFT = 21;
   localparam int P_SHIFT    = 15;

   localparam int NSTG = 9;

   localparam logic signed [TEMP_W-1:0] TEMP_COLD  = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_VCOLD = -19'sd1500;
   localparam logic signed [PROD_W-1:0] TRUNC_BIAS = (42'sd1 <<< TEMP_SHIFT) - 42'sd1;

   // calibration register codes
   typedef enum logic [IDX_W-1:0] {
      CSR_C1 = 3'd0,
      CSR_C2 = 3'd1,
      CSR_C3 = 3'd2,
      CSR_C4 = 3'd3,
      CSR_C5 = 3'd4,
      CSR_C6 = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [RAW_W-1:0]       d1;
      logic signed [DT_W-1:0] dt;
   } s1_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [PROD_W-1:0] pt;
      logic signed [PROD_W-1:0] po;
      logic signed [PROD_W-1:0] ps;
      logic [DTSQ_W-1:0]        dtsq;
   } s2_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic [T2_W-1:0]          t2;
   } s3_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic [T2_W-1:0]          t2;
      logic [SQ_W-1:0]          sqa;
      logic [SQ_W-1:0]          sqb;
      logic                     cold;
      logic                     vcold;
   } s4_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
      logic [T2_W-1:0]          t2;
      logic [CORR_W-1:0]        off2;
      logic [CORR_W-1:0]        sens2;
      logic                     cold;
      logic                     vcold;
   } s5_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
   } s6_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic [PLO_W-1:0]         plo;
      logic signed [PHI_W-1:0]  phi;
   } s7_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [PSH_W-1:0]  prod;
   } s8_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] temperature_centi;
      logic signed [OUT_W-1:0] pressure_value;
   } out_type;

endpackage

>>> rtl/barometer_pressure_temp_compensation.sv
// Barometer temperature and pressure compensation with second-order correction.
// Depends on bptc_pkg and assert_macros.svh.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_stall  | raw_pressure, raw_temperature
//   rsp     | out       | rsp_valid / rsp_stall  | temperature_centi, pressure_value
//   csr     | in        | csr_wr_en              | csr_index, csr_wdata (16 bits)
//
// Nine register stages; one word enters per cycle while req_stall is low.
// The pressure multiply D1*SENS is split into two partial products over two stages.
// Reset clears the calibration registers and the stage valid bits.
// A stalled result holds in the output stage; bubbles ahead of it keep filling,
// so req_stall rises only with all nine stages full and rsp_stall high.
`include "assert_macros.svh"

module barometer_pressure_temp_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bptc_pkg::RAW_W-1:0]           req_raw_pressure,
   input  logic [bptc_pkg::RAW_W-1:0]           req_raw_temperature,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bptc_pkg::OUT_W-1:0]    rsp_temperature_centi,
   output logic signed [bptc_pkg::OUT_W-1:0]    rsp_pressure_value,
   input  logic                                 csr_wr_en,
   input  logic [bptc_pkg::IDX_W-1:0]           csr_index,
   input  logic [bptc_pkg::CAL_W-1:0]           csr_wdata
);
   import bptc_pkg::*;

   // calibration words
   logic [CAL_W-1:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_C1:  c1_ff <= csr_wdata;
            CSR_C2:  c2_ff <= csr_wdata;
            CSR_C3:  c3_ff <= csr_wdata;
            CSR_C4:  c4_ff <= csr_wdata;
            CSR_C5:  c5_ff <= csr_wdata;
            CSR_C6:  c6_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valid bits and the ready chain
   logic [NSTG:1]   vld_ff, vld_in, vld_src;
   logic [NSTG+1:1] rdy;

   assign vld_src = {vld_ff[NSTG-1:1], req_valid};

   always_comb begin
      rdy[NSTG+1] = !rsp_stall;
      for (int i = NSTG; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   always_comb begin
      for (int i = 1; i <= NSTG; i++) begin
         vld_in[i] = rdy[i] ? vld_src[i] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !rdy[1];
   assign rsp_valid = vld_ff[NSTG];

   // stage registers
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   s7_type  s7_ff, s7_in;
   s8_type  s8_ff, s8_in;
   out_type out_ff, out_in;

   // stage 1: temperature difference
   always_comb begin
      s1_in.d1 = req_raw_pressure;
      s1_in.dt = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, c5_ff, 8'b0});
   end

   // stage 2: products with dT
   logic signed [2*DT_W-1:0] dtsq_full;

   always_comb begin
      dtsq_full   = $signed(s1_ff.dt) * $signed(s1_ff.dt);
      s2_in.d1    = s1_ff.d1;
      s2_in.pt    = $signed(s1_ff.dt) * $signed({1'b0, c6_ff});
      s2_in.po    = $signed(s1_ff.dt) * $signed({1'b0, c4_ff});
      s2_in.ps    = $signed(s1_ff.dt) * $signed({1'b0, c3_ff});
      s2_in.dtsq  = dtsq_full[DTSQ_W-1:0];
   end

   // stage 3: first-order TEMP, OFF, SENS and T2
   logic signed [PROD_W-1:0] pt_bias, temp_q, po_sh, ps_sh;

   always_comb begin
      // truncate toward zero: bias negative values before the shift
      pt_bias    = $signed(s2_ff.pt) + (s2_ff.pt[PROD_W-1] ? TRUNC_BIAS : 42'sd0);
      temp_q     = pt_bias >>> TEMP_SHIFT;
      po_sh      = $signed(s2_ff.po) >>> OFF_SHIFT;
      ps_sh      = $signed(s2_ff.ps) >>> SENS_SHIFT;
      s3_in.d1   = s2_ff.d1;
      s3_in.temp = TEMP_COLD + $signed(temp_q[TEMP_W-1:0]);
      s3_in.off  = $signed({8'b0, c2_ff, 16'b0}) + $signed(po_sh[ACC_W-1:0]);
      s3_in.sens = $signed({9'b0, c1_ff, 15'b0}) + $signed(ps_sh[ACC_W-1:0]);
      s3_in.t2   = s2_ff.dtsq[T2_SHIFT +: T2_W];
   end

   // stage 4: squares of the distance to the cold thresholds
   logic signed [TEMP_W-1:0]   dev_a, dev_b;
   logic signed [2*TEMP_W-1:0] sq_a, sq_b;

   always_comb begin
      dev_a       = $signed(s3_ff.temp) - TEMP_COLD;
      dev_b       = $signed(s3_ff.temp) - TEMP_VCOLD;
      sq_a        = dev_a * dev_a;
      sq_b        = dev_b * dev_b;
      s4_in.d1    = s3_ff.d1;
      s4_in.temp  = s3_ff.temp;
      s4_in.off   = s3_ff.off;
      s4_in.sens  = s3_ff.sens;
      s4_in.t2    = s3_ff.t2;
      s4_in.sqa   = sq_a[SQ_W-1:0];
      s4_in.sqb   = sq_b[SQ_W-1:0];
      s4_in.cold  = $signed(s3_ff.temp) < TEMP_COLD;
      s4_in.vcold = $signed(s3_ff.temp) < TEMP_VCOLD;
   end

   // stage 5: OFF2 and SENS2
   logic [SQ_W+1:0] f5;
   logic [SQ_W+2:0] f7;
   logic [SQ_W+3:0] f11;

   always_comb begin
      f5          = {s4_ff.sqa, 2'b0} + {2'b0, s4_ff.sqa};
      f7          = {s4_ff.sqb, 3'b0} - {3'b0, s4_ff.sqb};
      f11         = {1'b0, s4_ff.sqb, 3'b0} + {3'b0, s4_ff.sqb, 1'b0} + {4'b0, s4_ff.sqb};
      s5_in.d1    = s4_ff.d1;
      s5_in.temp  = s4_ff.temp;
      s5_in.off   = s4_ff.off;
      s5_in.sens  = s4_ff.sens;
      s5_in.t2    = s4_ff.t2;
      s5_in.cold  = s4_ff.cold;
      s5_in.vcold = s4_ff.vcold;
      s5_in.off2  = '0;
      s5_in.sens2 = '0;
      if (s4_ff.cold) begin
         s5_in.off2  = {2'b0, f5[SQ_W+1:1]} + (s4_ff.vcold ? f7 : '0);
         s5_in.sens2 = {3'b0, f5[SQ_W+1:2]} + (s4_ff.vcold ? f11[SQ_W+3:1] : '0);
      end
   end

   // stage 6: apply the corrections
   always_comb begin
      s6_in.d1   = s5_ff.d1;
      s6_in.off  = $signed(s5_ff.off) - $signed({2'b0, s5_ff.off2});
      s6_in.sens = $signed(s5_ff.sens) - $signed({2'b0, s5_ff.sens2});
      s6_in.temp = s5_ff.temp;
      if (s5_ff.cold) begin
         s6_in.temp = $signed(s5_ff.temp) - $signed({2'b0, s5_ff.t2});
      end
   end

   // stage 7: D1*SENS as two partial products
   always_comb begin
      s7_in.temp = s6_ff.temp;
      s7_in.off  = s6_ff.off;
      s7_in.plo  = s6_ff.d1 * s6_ff.sens[SPLIT-1:0];
      s7_in.phi  = $signed({1'b0, s6_ff.d1}) * $signed(s6_ff.sens[ACC_W-1:SPLIT]);
   end

   // stage 8: join the partial products, divide by 2^21
   logic signed [PHI_W+SPLIT:0] prod, prod_sh;

   always_comb begin
      prod       = $signed({s7_ff.phi, {SPLIT{1'b0}}}) + $signed({2'b0, s7_ff.plo});
      prod_sh    = prod >>> PROD_SHIFT;
      s8_in.temp = s7_ff.temp;
      s8_in.off  = s7_ff.off;
      s8_in.prod = prod_sh[PSH_W-1:0];
   end

   // stage 9: final pressure, output word
   logic signed [PSH_W:0] pdiff, pdiff_sh;

   always_comb begin
      pdiff                    = $signed(s8_ff.prod) - $signed(s8_ff.off);
      pdiff_sh                 = pdiff >>> P_SHIFT;
      out_in.temperature_centi = {{(OUT_W-TEMP_W){s8_ff.temp[TEMP_W-1]}}, s8_ff.temp};
      out_in.pressure_value    = pdiff_sh[OUT_W-1:0];
   end

   // payload moves wherever the stage is ready
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_ff <= s1_in;
      end
      if (rdy[2]) begin
         s2_ff <= s2_in;
      end
      if (rdy[3]) begin
         s3_ff <= s3_in;
      end
      if (rdy[4]) begin
         s4_ff <= s4_in;
      end
      if (rdy[5]) begin
         s5_ff <= s5_in;
      end
      if (rdy[6]) begin
         s6_ff <= s6_in;
      end
      if (rdy[7]) begin
         s7_ff <= s7_in;
      end
      if (rdy[8]) begin
         s8_ff <= s8_in;
      end
      if (rdy[9]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_temperature_centi = out_ff.temperature_centi;
   assign rsp_pressure_value    = out_ff.pressure_value;

   // checks
   `BPTC_ASSERT(a_stall_only_full, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled with room in the pipe")
   `BPTC_ASSERT(a_last_stage_moves, clock, reset, (vld_ff[NSTG-1] && rdy[NSTG]) |=> rsp_valid, "word lost before the output stage")
   `BPTC_ASSERT(a_stage8_holds, clock, reset, (vld_ff[NSTG-1] && !rdy[NSTG-1]) |=> (vld_ff[NSTG-1] && $stable(s8_ff)), "blocked stage changed")
   `BPTC_ASSERT(a_vcold_is_cold, clock, reset, (vld_ff[5] && s5_ff.vcold) |-> s5_ff.cold, "very cold flag without cold flag")

endmodule

>>> verif/tb_top.sv
// Testbench for the barometer temperature and pressure compensation block.
// Needs bptc_pkg and the block's RTL; random and directed words go through a queued driver and
// a self-checking monitor that compares every result word with an in-bench prediction.
`timescale 1ns / 100ps

module tb_top;
   import bptc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 20;     // idle time after the nine stages have emptied
   localparam int RAW_MAX      = (1 << RAW_W) - 1;
   localparam int DT_ZERO_D2   = 8388608; // D2 equal to C5*256 when C5 is 32768

   // indexes past the last calibration register, writes there must be ignored
   localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

   typedef struct {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } raw_word_type;

   typedef struct {
      logic signed [OUT_W-1:0] temperature_centi;
      logic signed [OUT_W-1:0] pressure_value;
   } comp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [RAW_W-1:0]        req_raw_pressure = '0;
   logic [RAW_W-1:0]        req_raw_temperature = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_temperature_centi;
   logic signed [OUT_W-1:0] rsp_pressure_value;
   logic                    csr_wr_en = 1'b0;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [CAL_W-1:0]        csr_wdata = '0;

   // bench copy of the calibration words
   logic [CAL_W-1:0] cal_model [6];

   raw_word_type    pending_words[$];
   comp_result_type expected_readings[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   logic            no_idle = 1'b0;

   barometer_pressure_temp_compensation i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_pressure      (req_raw_pressure),
      .req_raw_temperature   (req_raw_temperature),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_value    (rsp_pressure_value),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // First and second order compensation, all intermediates in 64 bits.
   // >>> on a signed longint floors, / truncates toward zero.
   function automatic comp_result_type compensate(input raw_word_type w);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, off2, sens2, sq, sq_vc, p;
      comp_result_type res;
      d1 = longint'(w.raw_pressure);
      d2 = longint'(w.raw_temperature);
      c1 = longint'(cal_model[CSR_C1]);
      c2 = longint'(cal_model[CSR_C2]);
      c3 = longint'(cal_model[CSR_C3]);
      c4 = longint'(cal_model[CSR_C4]);
      c5 = longint'(cal_model[CSR_C5]);
      c6 = longint'(cal_model[CSR_C6]);

      dt   = d2 - c5 * 256;
      temp = 2000 + (dt * c6) / 8388608;
      off  = c2 * 65536 + ((c4 * dt) >>> 7);
      sens = c1 * 32768 + ((c3 * dt) >>> 8);

      t2    = 0;
      off2  = 0;
      sens2 = 0;
      // cold reading: below 20.00 C
      if (temp < 2000) begin
         sq    = (temp - 2000) * (temp - 2000);
         t2    = (dt * dt) >>> 31;
         off2  = (5 * sq) / 2;
         sens2 = (5 * sq) / 4;
         // very cold reading: below -15.00 C
         if (temp < -1500) begin
            sq_vc = (temp + 1500) * (temp + 1500);
            off2  = off2 + 7 * sq_vc;
            sens2 = sens2 + (11 * sq_vc) / 2;
         end
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;

      p = (((d1 * sens) >>> 21) - off) >>> 15;
      res.temperature_centi = temp[OUT_W-1:0];
      res.pressure_value    = p[OUT_W-1:0];
      return res;
   endfunction

   // Random word: D2 either anywhere or near the reference point so that the
   // warm, cold and very cold paths all get traffic.
   function automatic raw_word_type random_word();
      raw_word_type w;
      int           centre, d2v, mode;
      mode = $urandom_range(99);
      w.raw_pressure = (mode % 10 == 0) ? ((mode < 50) ? '0 : RAW_MAX[RAW_W-1:0])
                                        : RAW_W'($urandom_range(RAW_MAX));
      centre = int'(cal_model[CSR_C5]) * 256;
      if (mode < 40) begin
         d2v = $urandom_range(RAW_MAX);
      end else if (mode < 85) begin
         d2v = centre + int'($urandom_range(2097151)) - 1048576;
      end else if (mode < 95) begin
         d2v = centre + int'($urandom_range(4095)) - 2048;
      end else begin
         d2v = ($urandom_range(1) == 1) ? RAW_MAX : 0;
      end
      if (d2v < 0) d2v = 0;
      if (d2v > RAW_MAX) d2v = RAW_MAX;
      w.raw_temperature = d2v[RAW_W-1:0];
      return w;
   endfunction

   task automatic queue_word(input int d1, input int d2);
      raw_word_type w;
      w.raw_pressure    = d1[RAW_W-1:0];
      w.raw_temperature = d2[RAW_W-1:0];
      pending_words.push_back(w);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) pending_words.push_back(random_word());
   endtask

   // wait until every word is sent and every result is back, then let the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || expected_readings.size() != 0 || req_valid);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx <= CSR_C6) cal_model[idx] = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_calibration(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                                  input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
                                  input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6);
      write_cal(CSR_C1, c1);
      write_cal(CSR_C2, c2);
      write_cal(CSR_C3, c3);
      write_cal(CSR_C4, c4);
      write_cal(CSR_C5, c5);
      write_cal(CSR_C6, c6);
   endtask

   // Driver: holds a stalled word, otherwise presents the next pending word or idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_readings.push_back(compensate(pending_words[0]));
            void'(pending_words.pop_front());
         end
         if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
            req_valid           <= 1'b1;
            req_raw_pressure    <= pending_words[0].raw_pressure;
            req_raw_temperature <= pending_words[0].raw_temperature;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random back-pressure and field-by-field check against the oldest prediction
   always @(posedge clock) begin
      comp_result_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result word temp=%0d pres=%0d", $time,
                        rsp_temperature_centi, rsp_pressure_value);
            end else begin
               exp_r = expected_readings.pop_front();
               if (rsp_temperature_centi !== exp_r.temperature_centi) begin
                  mismatch_count++;
                  $display("%0t: temperature_centi expected %0d actual %0d", $time,
                           exp_r.temperature_centi, rsp_temperature_centi);
               end
               if (rsp_pressure_value !== exp_r.pressure_value) begin
                  mismatch_count++;
                  $display("%0t: pressure_value expected %0d actual %0d", $time,
                           exp_r.pressure_value, rsp_pressure_value);
               end
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < 8);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 6; i++) cal_model[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // calibration still at its reset value
      queue_random(20);
      wait_idle();

      // directed words: C5*256 = 2^23 and C6 = 2^15, so TEMP = 2000 + trunc(dT/256)
      set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd32768);
      write_cal(IDX_SPARE_LO, 16'hFFFF);
      write_cal(IDX_SPARE_HI, 16'h5A5A);
      queue_word(0, 0);
      queue_word(RAW_MAX, RAW_MAX);
      queue_word(RAW_MAX, 0);
      queue_word(0, RAW_MAX);
      queue_word(6465444, DT_ZERO_D2);             // dT zero, exactly 20.00 C
      queue_word(6465444, DT_ZERO_D2 - 1);         // truncation toward zero keeps 2000
      queue_word(6465444, DT_ZERO_D2 - 255);
      queue_word(6465444, DT_ZERO_D2 - 256);       // first cold reading, 1999
      queue_word(6465444, DT_ZERO_D2 + 255);
      queue_word(RAW_MAX, DT_ZERO_D2 - 896000);    // -15.00 C, cold only
      queue_word(RAW_MAX, DT_ZERO_D2 - 896256);    // -15.01 C, very cold
      queue_word(24'hAAAAAA, 24'h555555);
      queue_word(24'h555555, 24'hAAAAAA);
      queue_word(1, DT_ZERO_D2 - 4000000);
      wait_idle();

      // typical calibration; the sender pauses halfway until everything is back
      set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
      queue_random(150);
      wait_idle();
      queue_random(150);
      wait_idle();

      // largest calibration words, run without any idling
      set_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      no_idle = 1'b1;
      queue_random(200);
      wait_idle();
      no_idle = 1'b0;

      // zero calibration, written explicitly
      set_calibration('0, '0, '0, '0, '0, '0);
      queue_random(100);
      wait_idle();

      // random calibration sets
      for (int k = 0; k < 6; k++) begin
         set_calibration(CAL_W'($urandom_range(65535)), CAL_W'($urandom_range(65535)),
                         CAL_W'($urandom_range(65535)), CAL_W'($urandom_range(65535)),
                         CAL_W'($urandom_range(65535)), CAL_W'($urandom_range(65535)));
         queue_random(100);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
